// ===== rtl/dltq_pkg.sv =====
package dltq_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int DELAY_BITS = 16;
  localparam int ID_BITS    = 8;

  localparam int CNT_BITS = $clog2(MAX_TIMERS + 1);
  localparam int IDX_BITS = $clog2(MAX_TIMERS);

  // Width of the pending_count field on the result word.
  localparam int PEND_BITS = 5;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ARM  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

endpackage

// ===== rtl/dltq_req_if.sv =====
interface dltq_req_if;
  import dltq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [DELAY_BITS-1:0] delay_seconds;
  logic [ID_BITS-1:0]    timer_id;

  modport source (output valid, output kind, output delay_seconds, output timer_id,
                  input ready);
  modport sink   (input valid, input kind, input delay_seconds, input timer_id,
                  output ready);
endinterface

// ===== rtl/dltq_rsp_if.sv =====
interface dltq_rsp_if;
  import dltq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 fired;
  logic [ID_BITS-1:0]   fired_id;
  logic [1:0]           set_status;
  logic [PEND_BITS-1:0] pending_count;

  modport source (output valid, output fired, output fired_id, output set_status,
                  output pending_count, input ready);
  modport sink   (input valid, input fired, input fired_id, input set_status,
                  input pending_count, output ready);
endinterface

// ===== rtl/delta_list_timer_queue.sv =====
// Channel | Dir | Word
// --------+-----+------------------------------------------------------
// req     | in  | kind, delay_seconds, timer_id (tick or arm request)
// rsp     | out | fired, fired_id, set_status, pending_count
//
// One item at a time. A tick is accepted, then updates the list. An arm
// request is accepted, then walks the list past at most MAX_TIMERS - 1
// entries, one compare-subtract of the shared unit per cycle, and inserts.
// Reset clears the entry count, the sequencer and the result valid flag; the
// delta and id stores are not cleared. The result register holds one word,
// and a new request is taken while it waits; that request only completes
// once the waiting word has been taken.
module delta_list_timer_queue (
  input logic       clk,
  input logic       rst,
  dltq_req_if.sink  req,
  dltq_rsp_if.source rsp
);
  import dltq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_ARM} state_t;

  state_t                state;
  logic [DELAY_BITS-1:0] delta_store [MAX_TIMERS];
  logic [ID_BITS-1:0]    id_store [MAX_TIMERS];
  logic [CNT_BITS-1:0]   entry_count;
  logic [DELAY_BITS-1:0] rem;
  logic [ID_BITS-1:0]    new_id;
  logic [IDX_BITS-1:0]   pos;

  logic                  rsp_valid;
  logic                  rsp_fired;
  logic [ID_BITS-1:0]    rsp_fired_id;
  logic [1:0]            rsp_status;

  // shared compare-subtract unit
  logic [DELAY_BITS-1:0] dsel;
  logic [DELAY_BITS:0]   diff;
  logic                  rem_lt;
  logic                  rem_eq;
  logic [DELAY_BITS-1:0] ins_delta;
  logic [DELAY_BITS-1:0] head_dec;
  logic                  out_free;
  logic                  at_end;
  logic                  full;
  logic                  arm_stop;
  logic                  done;
  logic [CNT_BITS+PEND_BITS-1:0] cnt_wide;

  assign dsel      = delta_store[pos];
  assign diff      = {1'b0, rem} - {1'b0, dsel};
  assign rem_lt    = diff[DELAY_BITS];
  assign rem_eq    = (diff == '0);
  assign ins_delta = DELAY_BITS'(~diff[DELAY_BITS-1:0] + 1'b1);
  assign head_dec  = delta_store[0] - 1'b1;
  assign out_free  = !rsp_valid || rsp.ready;
  assign at_end    = ({1'b0, pos} == entry_count);
  assign full      = (entry_count == CNT_BITS'(MAX_TIMERS));
  assign arm_stop  = (rem == '0) || full || at_end || rem_eq || rem_lt;
  // a word is loaded into the result register this cycle
  assign done      = out_free && ((state == S_TICK) || (state == S_ARM && arm_stop));
  assign cnt_wide  = (CNT_BITS+PEND_BITS)'(entry_count);

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.fired         = rsp_fired;
  assign rsp.fired_id      = rsp_fired_id;
  assign rsp.set_status    = rsp_status;
  assign rsp.pending_count = cnt_wide[PEND_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            rem    <= req.delay_seconds;
            new_id <= req.timer_id;
            pos    <= '0;
            state  <= (req.kind == KIND_ARM) ? S_ARM : S_TICK;
          end
        end
        S_TICK: begin
          if (out_free) begin
            rsp_status <= ST_OK;
            state      <= S_IDLE;
            if (entry_count != '0 && head_dec == '0) begin
              rsp_fired    <= 1'b1;
              rsp_fired_id <= id_store[0];
              entry_count  <= entry_count - 1'b1;
              for (int i = 0; i < MAX_TIMERS - 1; i++) begin
                delta_store[i] <= delta_store[i+1];
                id_store[i]    <= id_store[i+1];
              end
            end else begin
              rsp_fired    <= 1'b0;
              rsp_fired_id <= '0;
              if (entry_count != '0) begin
                delta_store[0] <= head_dec;
              end
            end
          end
        end
        S_ARM: begin
          if (arm_stop) begin
            if (out_free) begin
              rsp_fired    <= 1'b0;
              rsp_fired_id <= '0;
              state        <= S_IDLE;
              if (rem == '0) begin
                rsp_status <= ST_ZERO;
              end else if (full) begin
                rsp_status <= ST_FULL;
              end else if (!at_end && rem_eq) begin
                rsp_status <= ST_DUP;
              end else begin
                // insert at pos; entries from pos move up one place
                rsp_status  <= ST_OK;
                entry_count <= entry_count + 1'b1;
                for (int i = 0; i < MAX_TIMERS; i++) begin
                  if (IDX_BITS'(i) == pos) begin
                    delta_store[i] <= rem;
                    id_store[i]    <= new_id;
                  end
                end
                for (int i = 1; i < MAX_TIMERS; i++) begin
                  if (IDX_BITS'(i) > pos) begin
                    id_store[i] <= id_store[i-1];
                    if (IDX_BITS'(i - 1) == pos && !at_end) begin
                      delta_store[i] <= ins_delta;
                    end else begin
                      delta_store[i] <= delta_store[i-1];
                    end
                  end
                end
              end
            end
          end else begin
            rem <= diff[DELAY_BITS-1:0];
            pos <= pos + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_BITS'(MAX_TIMERS))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (entry_count == $past(entry_count) ||
                     entry_count == $past(entry_count) + 1'b1 ||
                     entry_count + 1'b1 == $past(entry_count)))
    else $error("entry count moved by more than one");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");

  a_fire_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.fired |-> rsp.set_status == ST_OK)
    else $error("fired word with arm status");
`endif

endmodule

// ===== verif/dltq_checker.sv =====
`timescale 1ns / 100ps

module dltq_checker (
  input  logic        clk,
  input  logic        rst,
  dltq_req_if         req,
  dltq_rsp_if         rsp,
  output int unsigned mismatches,
  output int unsigned backlog,
  output int unsigned n_fired,
  output int unsigned n_dup,
  output int unsigned n_full,
  output int unsigned n_zero
);
  import dltq_pkg::*;

  typedef struct packed {
    logic                 fired;
    logic [ID_BITS-1:0]   fired_id;
    logic [1:0]           status;
    logic [PEND_BITS-1:0] pending;
  } timer_word_t;

  // Shadow delta list: entry 0 is time left on the first timer to expire, later
  // entries are distances from the entry before.
  logic [DELAY_BITS-1:0] delta_q [MAX_TIMERS];
  logic [ID_BITS-1:0]    id_q    [MAX_TIMERS];
  int                    live = 0;

  timer_word_t owed_words[$];

  function automatic timer_word_t step_timers(input logic is_arm,
                                              input logic [DELAY_BITS-1:0] delay,
                                              input logic [ID_BITS-1:0] tid);
    timer_word_t           w;
    logic [DELAY_BITS-1:0] rem;
    int                    pos;
    int                    i;
    logic                  stop;
    w = '0;
    if (is_arm == KIND_TICK) begin
      if (live > 0) begin
        delta_q[0] = delta_q[0] - 1'b1;
        if (delta_q[0] == '0) begin
          w.fired    = 1'b1;
          w.fired_id = id_q[0];
          for (i = 1; i < live; i++) begin
            delta_q[i-1] = delta_q[i];
            id_q[i-1]    = id_q[i];
          end
          live--;
        end
      end
      w.status = ST_OK;
    end else begin
      rem = delay;
      if (rem == '0) begin
        w.status = ST_ZERO;
      end else if (live >= MAX_TIMERS) begin
        w.status = ST_FULL;
      end else begin
        w.status = ST_OK;
        pos      = 0;
        stop     = 1'b0;
        while (pos < live && !stop) begin
          if (rem == delta_q[pos]) begin
            w.status = ST_DUP;
            stop     = 1'b1;
          end else if (rem < delta_q[pos]) begin
            stop = 1'b1;
          end else begin
            rem = rem - delta_q[pos];
            pos++;
          end
        end
        if (w.status == ST_OK) begin
          // successor keeps only what is left beyond the new entry
          if (pos < live) delta_q[pos] = delta_q[pos] - rem;
          for (i = live; i > pos; i--) begin
            delta_q[i] = delta_q[i-1];
            id_q[i]    = id_q[i-1];
          end
          delta_q[pos] = rem;
          id_q[pos]    = tid;
          live++;
        end
      end
    end
    w.pending = PEND_BITS'(live);
    return w;
  endfunction

  task automatic report(input string what, input int unsigned want, input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    timer_word_t want;
    timer_word_t got;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.fired, rsp.fired_id, rsp.set_status, rsp.pending_count};
        if (owed_words.size() == 0) begin
          $display("%0t: unexpected word, got fired %0d id %0d status %0d pending %0d",
                   $time, got.fired, got.fired_id, got.status, got.pending);
          mismatches++;
        end else begin
          want = owed_words.pop_front();
          if (got.fired !== want.fired)       report("fired", want.fired, got.fired);
          if (got.fired_id !== want.fired_id) report("fired_id", want.fired_id, got.fired_id);
          if (got.status !== want.status)     report("set_status", want.status, got.status);
          if (got.pending !== want.pending)   report("pending_count", want.pending, got.pending);
        end
      end
      if (req.valid && req.ready) begin
        want = step_timers(req.kind, req.delay_seconds, req.timer_id);
        if (want.fired)              n_fired++;
        if (want.status == ST_DUP)  n_dup++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_ZERO) n_zero++;
        owed_words.push_back(want);
      end
    end
    backlog = owed_words.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import dltq_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int SEGMENTS    = 10;
  localparam int SEG_WORDS   = 48;

  logic clk;
  logic rst;

  dltq_req_if req_ch ();
  dltq_rsp_if rsp_ch ();

  int unsigned mismatches, backlog, n_fired, n_dup, n_full, n_zero;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct = 20;
  int unsigned stall_pct = 20;

  delta_list_timer_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  dltq_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .backlog    (backlog),
    .n_fired    (n_fired),
    .n_dup      (n_dup),
    .n_full     (n_full),
    .n_zero     (n_zero)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_word(input logic k, input logic [DELAY_BITS-1:0] d,
                           input logic [ID_BITS-1:0] t);
    @(negedge clk);
    if ($urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= k;
    req_ch.delay_seconds <= d;
    req_ch.timer_id      <= t;
    do @(posedge clk); while (!req_ch.ready);
    words_sent++;
  endtask

  // Mostly short delays so expiries and duplicates are common; a few long
  // ones sit at the tail of the list.
  task automatic send_random(input int unsigned tick_pct);
    int unsigned pick;
    logic [DELAY_BITS-1:0] d;
    pick = $urandom_range(0, 99);
    if (pick < 4)      d = '0;
    else if (pick < 6) d = DELAY_BITS'($urandom_range(0, 65535));
    else               d = DELAY_BITS'($urandom_range(1, 24));
    if ($urandom_range(0, 99) < tick_pct)
      send_word(KIND_TICK, DELAY_BITS'($urandom), ID_BITS'($urandom));
    else
      send_word(KIND_ARM, d, ID_BITS'($urandom));
  endtask

  // sink side backpressure
  initial begin
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned tick_pct;
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.kind          = KIND_TICK;
    req_ch.delay_seconds = '0;
    req_ch.timer_id      = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty tick, zero delay, head/mid duplicates, long delay,
    // expiry, fill to capacity, then a request against a full list
    send_word(KIND_TICK, '0, '0);
    send_word(KIND_ARM, '0, 8'hFF);
    send_word(KIND_ARM, 16'd5, 8'h00);
    send_word(KIND_ARM, 16'd5, 8'h01);
    send_word(KIND_ARM, 16'd3, 8'h02);
    send_word(KIND_ARM, 16'hFFFF, 8'hFF);
    send_word(KIND_ARM, 16'd1, 8'h03);
    send_word(KIND_TICK, '0, '0);
    send_word(KIND_ARM, 16'd4, 8'h04);
    send_word(KIND_TICK, 16'hFFFF, 8'hFF);
    send_word(KIND_TICK, '0, '0);
    for (int n = 0; n < 14; n++)
      send_word(KIND_ARM, DELAY_BITS'(n + 3), ID_BITS'(n + 16));
    send_word(KIND_ARM, 16'd7, 8'h55);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 2))
        0:       tick_pct = 30;
        1:       tick_pct = 50;
        default: tick_pct = 70;
      endcase
      if (seg == 4 || seg == SEGMENTS - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(10, 40);
        stall_pct = $urandom_range(10, 40);
      end
      for (int n = 0; n < SEG_WORDS; n++) send_random(tick_pct);
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    while (backlog != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d words: %0d expiries, %0d duplicate expiries dropped,", words_sent,
             n_fired, n_dup);
    $display("%0d requests refused on a full list, %0d zero-delay requests ignored",
             n_full, n_zero);
    if (mismatches == 0 && backlog == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dltq_pkg.sv
rtl/dltq_req_if.sv
rtl/dltq_rsp_if.sv
rtl/delta_list_timer_queue.sv
verif/dltq_checker.sv
verif/testbench.sv
